// ===== src/aps_pkg.sv =====
// Shared constants and codes for the aging priority scheduler.
// No dependencies; the top level refers to these by scoped names.
package aps_pkg;

  localparam int SLOT_COUNT_DEF = 16;

  localparam int CMD_W  = 3;
  localparam int PID_W  = 5;
  localparam int PRIO_W = 8;
  localparam int DYN_W  = 16;
  localparam int OUTC_W = 2;
  localparam int STAT_W = 2;

  localparam logic [DYN_W-1:0] DYN_MAX = '1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_RESCHED  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FORK     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_EXIT     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_KILL     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SET_PRIO = 3'd4;

  // slot status codes
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd0;
  localparam logic [STAT_W-1:0] ST_READY   = 2'd1;
  localparam logic [STAT_W-1:0] ST_RUNNING = 2'd2;

  // outcome codes
  localparam logic [OUTC_W-1:0] OUTC_DONE    = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_NO_SLOT = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_BAD_TGT = 2'd2;

endpackage

// ===== src/aging_priority_scheduler_top.sv =====
// Aging priority scheduler: process slot table plus a one-slot-per-cycle scan sequencer.
// Depends on aps_pkg (widths, command, status and outcome codes).
//
// Usage:
//   Input channel (in_valid / in_stall): one word carries a command, a target
//   pid and a new base priority. Output channel (out_valid / out_stall): one
//   word per input word with the running pid, the previous pid, the forked pid
//   and an outcome code.
//   Slot walks go through a single slot index register, so one slot is
//   visited per cycle. Reschedule, exit and a successful kill walk all
//   SLOT_COUNT slots (aging plus max search), then demote the old runner
//   and load the winner; kill first checks its target slot. Fork walks
//   until the first free slot or the end of the table. Set-priority,
//   unknown commands and a kill of an out-of-range pid go straight to the
//   result word.
//   in_stall is high from accept until the result word is taken; one word is
//   in flight at a time. While out_stall is high the result word holds.
//   Reset (synchronous, rst_n low): slot 0 ready and running_valid set with
//   running slot 0, all other slots invalid, all priorities zero.
module aging_priority_scheduler_top #(
  parameter int SLOT_COUNT = aps_pkg::SLOT_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [aps_pkg::CMD_W-1:0]   in_command,
  input  logic [aps_pkg::PID_W-1:0]   in_target_pid,
  input  logic [aps_pkg::PRIO_W-1:0]  in_new_priority,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [aps_pkg::PID_W-1:0]   out_running_pid,
  output logic [aps_pkg::PID_W-1:0]   out_previous_pid,
  output logic [aps_pkg::PID_W-1:0]   out_forked_pid,
  output logic [aps_pkg::OUTC_W-1:0]  out_outcome
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_KILL,    // check target slot status
    S_FORK,    // search first invalid slot
    S_SCAN,    // age and find max, one slot per cycle
    S_DEMOTE,  // old runner back to ready
    S_WIN,     // load winner
    S_OUT
  } state_t;

  state_t state_r;

  // slot table
  logic [aps_pkg::STAT_W-1:0] status_r [SLOT_COUNT];
  logic [aps_pkg::DYN_W-1:0]  dyn_r    [SLOT_COUNT];
  logic [aps_pkg::PRIO_W-1:0] base_r   [SLOT_COUNT];
  logic [IDX_W-1:0]           run_slot_r;
  logic                       run_valid_r;

  // sequencer
  logic [IDX_W-1:0]           idx_r;
  logic [aps_pkg::DYN_W-1:0]  best_r;
  logic [IDX_W-1:0]           win_r;
  logic                       found_r;

  // result word
  logic [aps_pkg::PID_W-1:0]  prev_pid_r;
  logic [aps_pkg::PID_W-1:0]  fork_pid_r;
  logic [aps_pkg::OUTC_W-1:0] outcome_r;

  // shared slot datapath, all reads at idx_r
  logic [aps_pkg::STAT_W-1:0] cur_st;
  logic [aps_pkg::DYN_W-1:0]  cur_dyn;
  logic [aps_pkg::DYN_W-1:0]  aged_dyn;
  logic                       cur_elig;
  logic                       take_win;
  logic [aps_pkg::PID_W-1:0]  idx_pid;
  logic [aps_pkg::PID_W-1:0]  run_pid;
  logic                       tgt_ok;
  logic [IDX_W-1:0]           tgt_idx;

  assign cur_st   = status_r[idx_r];
  assign cur_dyn  = dyn_r[idx_r];
  assign aged_dyn = (cur_st == aps_pkg::ST_READY && cur_dyn != aps_pkg::DYN_MAX) ?
                    cur_dyn + 1'b1 : cur_dyn;
  assign cur_elig = (cur_st == aps_pkg::ST_READY) || (cur_st == aps_pkg::ST_RUNNING);
  // >= so that the later slot wins a tie
  assign take_win = cur_elig && (aged_dyn >= best_r);

  assign idx_pid  = aps_pkg::PID_W'({1'b0, idx_r} + 1'b1);
  assign run_pid  = run_valid_r ? aps_pkg::PID_W'({1'b0, run_slot_r} + 1'b1) : '0;
  assign tgt_ok   = (in_target_pid != '0) && (int'(in_target_pid) <= SLOT_COUNT);
  assign tgt_idx  = IDX_W'(in_target_pid - 1'b1);

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = (state_r == S_OUT);
  assign out_running_pid  = run_pid;
  assign out_previous_pid = prev_pid_r;
  assign out_forked_pid   = fork_pid_r;
  assign out_outcome      = outcome_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_slot_r  <= '0;
      run_valid_r <= 1'b1;
      idx_r       <= '0;
      best_r      <= '0;
      win_r       <= '0;
      found_r     <= 1'b0;
      prev_pid_r  <= '0;
      fork_pid_r  <= '0;
      outcome_r   <= aps_pkg::OUTC_DONE;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        status_r[i] <= (i == 0) ? aps_pkg::ST_READY : aps_pkg::ST_INVALID;
        dyn_r[i]    <= '0;
        base_r[i]   <= '0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          // kill looks at its target first; every other walk starts at slot 0
          idx_r   <= (in_command == aps_pkg::CMD_KILL && tgt_ok) ? tgt_idx : '0;
          best_r  <= '0;
          found_r <= 1'b0;
          if (in_valid) begin
            prev_pid_r <= run_pid;
            fork_pid_r <= '0;
            case (in_command)
              aps_pkg::CMD_RESCHED: begin
                outcome_r <= aps_pkg::OUTC_DONE;
                state_r   <= S_SCAN;
              end
              aps_pkg::CMD_FORK: begin
                outcome_r <= aps_pkg::OUTC_DONE;
                state_r   <= S_FORK;
              end
              aps_pkg::CMD_EXIT: begin
                if (run_valid_r) status_r[run_slot_r] <= aps_pkg::ST_INVALID;
                outcome_r <= aps_pkg::OUTC_DONE;
                state_r   <= S_SCAN;
              end
              aps_pkg::CMD_KILL: begin
                if (tgt_ok) begin
                  outcome_r <= aps_pkg::OUTC_DONE;
                  state_r   <= S_KILL;
                end else begin
                  outcome_r <= aps_pkg::OUTC_BAD_TGT;
                  state_r   <= S_OUT;
                end
              end
              aps_pkg::CMD_SET_PRIO: begin
                if (tgt_ok) base_r[tgt_idx] <= in_new_priority;
                outcome_r <= tgt_ok ? aps_pkg::OUTC_DONE : aps_pkg::OUTC_BAD_TGT;
                state_r   <= S_OUT;
              end
              default: begin
                outcome_r <= aps_pkg::OUTC_DONE;
                state_r   <= S_OUT;
              end
            endcase
          end
        end
        S_KILL: begin
          idx_r <= '0;
          if (cur_st != aps_pkg::ST_INVALID) begin
            status_r[idx_r] <= aps_pkg::ST_INVALID;
            state_r         <= S_SCAN;
          end else begin
            outcome_r <= aps_pkg::OUTC_BAD_TGT;
            state_r   <= S_OUT;
          end
        end
        S_FORK: begin
          if (cur_st == aps_pkg::ST_INVALID) begin
            status_r[idx_r] <= aps_pkg::ST_READY;
            fork_pid_r      <= idx_pid;
            state_r         <= S_OUT;
          end else if (idx_r == LAST_IDX) begin
            outcome_r <= aps_pkg::OUTC_NO_SLOT;
            state_r   <= S_OUT;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_SCAN: begin
          dyn_r[idx_r] <= aged_dyn;
          if (take_win) begin
            best_r  <= aged_dyn;
            win_r   <= idx_r;
            found_r <= 1'b1;
          end
          if (idx_r == LAST_IDX) begin
            idx_r   <= run_slot_r;
            state_r <= S_DEMOTE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_DEMOTE: begin
          if (run_valid_r && cur_st == aps_pkg::ST_RUNNING)
            status_r[idx_r] <= aps_pkg::ST_READY;
          idx_r   <= win_r;
          state_r <= S_WIN;
        end
        S_WIN: begin
          if (found_r) begin
            dyn_r[idx_r]    <= aps_pkg::DYN_W'(base_r[idx_r]);
            status_r[idx_r] <= aps_pkg::ST_RUNNING;
            run_slot_r      <= idx_r;
            run_valid_r     <= 1'b1;
          end else begin
            run_slot_r  <= '0;
            run_valid_r <= 1'b0;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a result word is only offered while input is held off
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("result offered while input open");

  // an accepted word always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted word did not start work");

  // the slot index never leaves the table
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= LAST_IDX)
    else $error("slot index out of range");

  // a winner was loaded as running
  a_win_runs: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WIN && found_r |=> run_valid_r && status_r[run_slot_r] == aps_pkg::ST_RUNNING)
    else $error("winner not marked running");

endmodule

// ===== bench/testbench.sv =====
// Testbench for aging_priority_scheduler_top: directed table, then random command traffic.
// Depends on aps_pkg and the scheduler RTL; the scheduler behavior is predicted in place.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_COUNT   = aps_pkg::SLOT_COUNT_DEF;
  localparam int RAND_WORDS   = 550;
  localparam int DRAIN_CYCLES = 40;      // one full scan plus handshake, with margin
  localparam int LIMIT_CYCLES = 200000;  // watchdog bound for ~575 words, with wide margin

  // Commands the block must ignore (outcome done, nothing changes).
  localparam logic [aps_pkg::CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [aps_pkg::CMD_W-1:0] CMD_SPARE_MID = 3'd6;
  localparam logic [aps_pkg::CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

  // One result word, in port order.
  typedef struct packed {
    logic [aps_pkg::PID_W-1:0]  running_pid;
    logic [aps_pkg::PID_W-1:0]  previous_pid;
    logic [aps_pkg::PID_W-1:0]  forked_pid;
    logic [aps_pkg::OUTC_W-1:0] outcome;
  } sched_word_t;

  // One row of the directed table. When hand_set is set, the row carries its own
  // answer; otherwise the process table below supplies it.
  typedef struct {
    logic [aps_pkg::CMD_W-1:0]  cmd;
    logic [aps_pkg::PID_W-1:0]  tgt;
    logic [aps_pkg::PRIO_W-1:0] prio;
    bit                         hand_set;
    sched_word_t                answer;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [aps_pkg::CMD_W-1:0]  in_command = '0;
  logic [aps_pkg::PID_W-1:0]  in_target_pid = '0;
  logic [aps_pkg::PRIO_W-1:0] in_new_priority = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [aps_pkg::PID_W-1:0]  out_running_pid;
  logic [aps_pkg::PID_W-1:0]  out_previous_pid;
  logic [aps_pkg::PID_W-1:0]  out_forked_pid;
  logic [aps_pkg::OUTC_W-1:0] out_outcome;

  // Shadow process table, advanced once per accepted word.
  logic [aps_pkg::STAT_W-1:0] slot_st   [SLOT_COUNT];
  logic [aps_pkg::DYN_W-1:0]  dyn_prio  [SLOT_COUNT];
  logic [aps_pkg::PRIO_W-1:0] base_prio [SLOT_COUNT];
  int                         run_slot;
  bit                         run_valid;

  sched_word_t due_words[$];  // result words owed by the block, oldest first
  plan_row_t   plan[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          calm = 1'b0;   // while set, neither side idles

  aging_priority_scheduler_top #(.SLOT_COUNT(SLOT_COUNT)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_target_pid   (in_target_pid),
    .in_new_priority (in_new_priority),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_running_pid (out_running_pid),
    .out_previous_pid(out_previous_pid),
    .out_forked_pid  (out_forked_pid),
    .out_outcome     (out_outcome)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // ---------------------------------------------------------------------------
  // Process table prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_table();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_st[i]   = aps_pkg::ST_INVALID;
      dyn_prio[i]  = '0;
      base_prio[i] = '0;
    end
    // After reset slot 0 is ready (not running) yet counts as the runner.
    slot_st[0] = aps_pkg::ST_READY;
    run_slot   = 0;
    run_valid  = 1'b1;
  endfunction

  function automatic logic [aps_pkg::PID_W-1:0] current_pid();
    return run_valid ? aps_pkg::PID_W'(run_slot + 1) : '0;
  endfunction

  // Age every ready slot, then pick the highest dynamic priority among ready and
  // running slots; ">=" makes the later slot win a tie.
  function automatic void rerun_scheduler();
    logic [aps_pkg::DYN_W-1:0] best;
    int                        winner;
    bit                        found;
    best   = '0;
    winner = 0;
    found  = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slot_st[i] == aps_pkg::ST_READY && dyn_prio[i] != aps_pkg::DYN_MAX)
        dyn_prio[i] = dyn_prio[i] + 1'b1;
      if ((slot_st[i] == aps_pkg::ST_READY || slot_st[i] == aps_pkg::ST_RUNNING) &&
          dyn_prio[i] >= best) begin
        best   = dyn_prio[i];
        winner = i;
        found  = 1'b1;
      end
    end
    // Old runner goes back to ready only if it is still marked running.
    if (run_valid && slot_st[run_slot] == aps_pkg::ST_RUNNING)
      slot_st[run_slot] = aps_pkg::ST_READY;
    if (found) begin
      dyn_prio[winner] = aps_pkg::DYN_W'(base_prio[winner]);
      slot_st[winner]  = aps_pkg::ST_RUNNING;
      run_slot         = winner;
      run_valid        = 1'b1;
    end else begin
      run_slot  = 0;
      run_valid = 1'b0;
    end
  endfunction

  // Apply one command to the shadow table and return the word the block owes.
  function automatic sched_word_t apply_command(logic [aps_pkg::CMD_W-1:0] cmd,
                                                logic [aps_pkg::PID_W-1:0] tgt,
                                                logic [aps_pkg::PRIO_W-1:0] prio);
    sched_word_t w;
    bit          tgt_ok;
    int          tidx;
    bit          got;
    w.previous_pid = current_pid();
    w.forked_pid   = '0;
    w.outcome      = aps_pkg::OUTC_DONE;
    tgt_ok = (tgt >= 1 && tgt <= SLOT_COUNT);
    tidx   = tgt_ok ? int'(tgt) - 1 : 0;
    got    = 1'b0;
    case (cmd)
      aps_pkg::CMD_RESCHED: rerun_scheduler();
      aps_pkg::CMD_FORK: begin
        // Lowest free slot; priorities stay as they were, no reschedule.
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!got && slot_st[i] == aps_pkg::ST_INVALID) begin
            slot_st[i]   = aps_pkg::ST_READY;
            w.forked_pid = aps_pkg::PID_W'(i + 1);
            got          = 1'b1;
          end
        end
        if (!got) w.outcome = aps_pkg::OUTC_NO_SLOT;
      end
      aps_pkg::CMD_EXIT: begin
        if (run_valid) slot_st[run_slot] = aps_pkg::ST_INVALID;
        rerun_scheduler();
      end
      aps_pkg::CMD_KILL: begin
        // A bad or dead target leaves everything alone, no reschedule.
        if (tgt_ok && slot_st[tidx] != aps_pkg::ST_INVALID) begin
          slot_st[tidx] = aps_pkg::ST_INVALID;
          rerun_scheduler();
        end else begin
          w.outcome = aps_pkg::OUTC_BAD_TGT;
        end
      end
      aps_pkg::CMD_SET_PRIO: begin
        // Written whatever the slot's status; dynamic priority untouched.
        if (tgt_ok) base_prio[tidx] = prio;
        else        w.outcome = aps_pkg::OUTC_BAD_TGT;
      end
      default: ;
    endcase
    w.running_pid = current_pid();
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------

  function automatic void add_row(logic [aps_pkg::CMD_W-1:0] cmd,
                                  logic [aps_pkg::PID_W-1:0] tgt,
                                  logic [aps_pkg::PRIO_W-1:0] prio, bit hand_set,
                                  sched_word_t answer);
    plan_row_t r;
    r.cmd      = cmd;
    r.tgt      = tgt;
    r.prio     = prio;
    r.hand_set = hand_set;
    r.answer   = answer;
    plan.push_back(r);
  endfunction

  function automatic void build_plan();
    // From reset pid 1 counts as running; the first reschedule keeps it.
    add_row(aps_pkg::CMD_RESCHED,  5'd0,  8'h00,
            1, '{5'd1, 5'd1, 5'd0, aps_pkg::OUTC_DONE});
    add_row(CMD_SPARE_HI,          5'd31, 8'hFF,
            1, '{5'd1, 5'd1, 5'd0, aps_pkg::OUTC_DONE});
    add_row(CMD_SPARE_LO,          5'd9,  8'h3C,
            1, '{5'd1, 5'd1, 5'd0, aps_pkg::OUTC_DONE});
    // Target ids out of range.
    add_row(aps_pkg::CMD_SET_PRIO, 5'd0,  8'hAA,
            1, '{5'd1, 5'd1, 5'd0, aps_pkg::OUTC_BAD_TGT});
    add_row(aps_pkg::CMD_SET_PRIO, 5'd17, 8'h55,
            1, '{5'd1, 5'd1, 5'd0, aps_pkg::OUTC_BAD_TGT});
    add_row(aps_pkg::CMD_SET_PRIO, 5'd31, 8'hFF,
            1, '{5'd1, 5'd1, 5'd0, aps_pkg::OUTC_BAD_TGT});
    add_row(aps_pkg::CMD_KILL,     5'd0,  8'h00,
            1, '{5'd1, 5'd1, 5'd0, aps_pkg::OUTC_BAD_TGT});
    add_row(aps_pkg::CMD_KILL,     5'd31, 8'h00,
            1, '{5'd1, 5'd1, 5'd0, aps_pkg::OUTC_BAD_TGT});
    // Kill of a slot that was never forked.
    add_row(aps_pkg::CMD_KILL,     5'd5,  8'h00,
            1, '{5'd1, 5'd1, 5'd0, aps_pkg::OUTC_BAD_TGT});
    // Killing the only process leaves nothing eligible.
    add_row(aps_pkg::CMD_KILL,     5'd1,  8'h00,
            1, '{5'd0, 5'd1, 5'd0, aps_pkg::OUTC_DONE});
    add_row(aps_pkg::CMD_EXIT,     5'd0,  8'h00,
            1, '{5'd0, 5'd0, 5'd0, aps_pkg::OUTC_DONE});
    add_row(aps_pkg::CMD_RESCHED,  5'd0,  8'h00,
            1, '{5'd0, 5'd0, 5'd0, aps_pkg::OUTC_DONE});
    add_row(aps_pkg::CMD_FORK,     5'd0,  8'h00,
            1, '{5'd0, 5'd0, 5'd1, aps_pkg::OUTC_DONE});
    add_row(aps_pkg::CMD_FORK,     5'd0,  8'h00,
            1, '{5'd0, 5'd0, 5'd2, aps_pkg::OUTC_DONE});
    // Base priority written into a free slot, kept across a later fork.
    add_row(aps_pkg::CMD_SET_PRIO, 5'd16, 8'hFF,
            1, '{5'd0, 5'd0, 5'd0, aps_pkg::OUTC_DONE});
    add_row(aps_pkg::CMD_SET_PRIO, 5'd2,  8'hFF,
            1, '{5'd0, 5'd0, 5'd0, aps_pkg::OUTC_DONE});
    add_row(aps_pkg::CMD_SET_PRIO, 5'd1,  8'h00,
            1, '{5'd0, 5'd0, 5'd0, aps_pkg::OUTC_DONE});
    // From here on the shadow table answers: ties, aging, exit and kill of an exited process.
    add_row(aps_pkg::CMD_RESCHED,  5'd0,  8'h00, 0, '0);
    add_row(aps_pkg::CMD_RESCHED,  5'd0,  8'h00, 0, '0);
    add_row(aps_pkg::CMD_FORK,     5'd0,  8'h00, 0, '0);
    add_row(aps_pkg::CMD_SET_PRIO, 5'd3,  8'h80, 0, '0);
    add_row(aps_pkg::CMD_RESCHED,  5'd0,  8'h00, 0, '0);
    add_row(aps_pkg::CMD_EXIT,     5'd0,  8'h00, 0, '0);
    add_row(aps_pkg::CMD_KILL,     5'd2,  8'h00, 0, '0);
    add_row(CMD_SPARE_MID,         5'd4,  8'h11, 0, '0);
    add_row(aps_pkg::CMD_RESCHED,  5'd0,  8'h00, 0, '0);
  endfunction

  // ---------------------------------------------------------------------------
  // Random commands
  // ---------------------------------------------------------------------------

  // Mix of commands per traffic mode: fill the table, drain it, or churn.
  // Thresholds are cumulative percent for fork, reschedule, set, kill, exit;
  // the remainder goes to unused command codes.
  int mix[3][5] = '{'{55, 75, 85, 92, 97},
                    '{15, 35, 45, 80, 97},
                    '{25, 60, 75, 87, 97}};

  function automatic logic [aps_pkg::PRIO_W-1:0] pick_priority();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30)      return aps_pkg::PRIO_W'($urandom_range(0, 7));
    else if (r < 35) return '0;
    else if (r < 40) return '1;
    else             return aps_pkg::PRIO_W'($urandom);
  endfunction

  task automatic make_random_word(input int mode, output logic [aps_pkg::CMD_W-1:0] cmd,
                                  output logic [aps_pkg::PID_W-1:0] tgt,
                                  output logic [aps_pkg::PRIO_W-1:0] prio);
    int r;
    int live[$];
    r    = $urandom_range(0, 99);
    tgt  = aps_pkg::PID_W'($urandom);
    prio = aps_pkg::PRIO_W'($urandom);
    if (r < mix[mode][0]) begin
      cmd = aps_pkg::CMD_FORK;
    end else if (r < mix[mode][1]) begin
      cmd = aps_pkg::CMD_RESCHED;
    end else if (r < mix[mode][2]) begin
      cmd  = aps_pkg::CMD_SET_PRIO;
      prio = pick_priority();
      if ($urandom_range(0, 99) < 85) tgt = aps_pkg::PID_W'($urandom_range(1, SLOT_COUNT));
      else if ($urandom_range(0, 1))  tgt = '0;
      else                            tgt = aps_pkg::PID_W'($urandom_range(SLOT_COUNT + 1, 31));
    end else if (r < mix[mode][3]) begin
      cmd = aps_pkg::CMD_KILL;
      // Mostly a live process, otherwise any id.
      for (int i = 0; i < SLOT_COUNT; i++)
        if (slot_st[i] != aps_pkg::ST_INVALID) live.push_back(i);
      if (live.size() > 0 && $urandom_range(0, 99) < 80)
        tgt = aps_pkg::PID_W'(live[$urandom_range(0, live.size() - 1)] + 1);
    end else if (r < mix[mode][4]) begin
      cmd = aps_pkg::CMD_EXIT;
    end else begin
      cmd = aps_pkg::CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side: drive one word, hold it until accepted, then predict.
  // ---------------------------------------------------------------------------

  task automatic push_word(input logic [aps_pkg::CMD_W-1:0] cmd,
                           input logic [aps_pkg::PID_W-1:0] tgt,
                           input logic [aps_pkg::PRIO_W-1:0] prio, input bit hand_set,
                           input sched_word_t answer);
    sched_word_t predicted;
    if (!calm) begin
      while ($urandom_range(0, 99) < 10) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_target_pid   <= tgt;
    in_new_priority <= prio;
    do @(posedge clk); while (in_stall);
    predicted = apply_command(cmd, tgt, prio);
    due_words.push_back(hand_set ? answer : predicted);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall, compare every word taken.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 10);
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    sched_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_words.size() == 0) begin
        $error("result word with none outstanding");
        fail_count++;
      end else begin
        want = due_words.pop_front();
        check_field("running_pid",  8'(want.running_pid),  8'(out_running_pid));
        check_field("previous_pid", 8'(want.previous_pid), 8'(out_previous_pid));
        check_field("forked_pid",   8'(want.forked_pid),   8'(out_forked_pid));
        check_field("outcome",      8'(want.outcome),      8'(out_outcome));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed table, random traffic, drain, verdict.
  // ---------------------------------------------------------------------------

  initial begin
    int                         mode;
    logic [aps_pkg::CMD_W-1:0]  cmd;
    logic [aps_pkg::PID_W-1:0]  tgt;
    logic [aps_pkg::PRIO_W-1:0] prio;
    mode = 0;
    clear_table();
    build_plan();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[k])
      push_word(plan[k].cmd, plan[k].tgt, plan[k].prio, plan[k].hand_set, plan[k].answer);

    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n % 30 == 0) mode = $urandom_range(0, 2);
      // Back-to-back stretch with no idling on either side.
      calm = (n >= 100 && n < 250);
      // Sender holds off until the block owes nothing.
      if (n == 300) begin
        while (due_words.size() != 0) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
      end
      make_random_word(mode, cmd, tgt, prio);
      push_word(cmd, tgt, prio, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog.
  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("Test completed with failures");
    $finish;
  end

endmodule
